[design/lzvn_stream_decoder_unit_assert.svh]
// Assertion macros for the LZVN stream decoder checker
`ifndef LZVN_STREAM_DECODER_UNIT_ASSERT_SVH
`define LZVN_STREAM_DECODER_UNIT_ASSERT_SVH
// Clocked check, switched off while reset is low
`define LZVN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define LZVN_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[design/lzvn_pkg.sv]
// Shared types, constants and opcode decode for the LZVN stream decoder
`default_nettype none
package lzvn_pkg;
	localparam int HISTORY_BYTES  = 65536;
	localparam int HIST_AW        = $clog2(HISTORY_BYTES);
	localparam int OUT_WORD_BYTES = 8;

	// Status codes
	localparam logic [2:0] ST_RUN     = 3'd0;
	localparam logic [2:0] ST_END     = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_BAD_OP  = 3'd3;
	localparam logic [2:0] ST_BAD_DST = 3'd4;
	localparam logic [2:0] ST_OVERRUN = 3'd5;

	// Register indexes
	localparam logic REG_SRC_LEN = 1'b0;
	localparam logic REG_OUT_CAP = 1'b1;

	typedef enum logic [3:0] {
		K_SMLD = 4'd0, K_PRED = 4'd1, K_LRGD = 4'd2, K_MEDD = 4'd3,
		K_EOS  = 4'd4, K_NOP  = 4'd5, K_UDEF = 4'd6, K_SMLL = 4'd7,
		K_LRGL = 4'd8, K_SMLM = 4'd9, K_LRGM = 4'd10
	} kind_t;

	// Control from the sequencer to the output packer
	typedef struct packed {
		logic        put;
		logic [7:0]  data;
		logic [31:0] pos;
		logic        fin;
		logic [2:0]  status;
		logic [31:0] fpos;
	} pack_ctl_t;

	function automatic kind_t kind_of(input logic [7:0] b);
		kind_t k;
		if (b >= 8'hF0) k = (b == 8'hF0) ? K_LRGM : K_SMLM;
		else if (b >= 8'hE0) k = (b == 8'hE0) ? K_LRGL : K_SMLL;
		else if (b >= 8'hA0 && b <= 8'hBF) k = K_MEDD;
		else if ((b >= 8'h70 && b <= 8'h7F) || (b >= 8'hD0 && b <= 8'hDF)) k = K_UDEF;
		else if (b[2:0] == 3'd7) k = K_LRGD;
		else if (b[2:0] == 3'd6) begin
			if (b == 8'h06) k = K_EOS;
			else if (b == 8'h0E || b == 8'h16) k = K_NOP;
			else if (b < 8'h40) k = K_UDEF;
			else k = K_PRED;
		end else k = K_SMLD;
		return k;
	endfunction

	function automatic logic [1:0] hdr_len(input kind_t k);
		logic [1:0] n;
		unique case (k)
			K_LRGD, K_MEDD:         n = 2'd3;
			K_SMLD, K_LRGL, K_LRGM: n = 2'd2;
			default:                n = 2'd1;
		endcase
		return n;
	endfunction
endpackage
`default_nettype wire

[design/lzvn_ram.sv]
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module lzvn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[design/lzvn_pack.sv]
// Output packer: gathers decoded bytes into words and holds the result beat
`default_nettype none
module lzvn_pack (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lzvn_pkg::pack_ctl_t ctl,
	output logic                     busy,
	output logic                     word_full,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [103:0]             m_tdata,
	output logic                     m_tlast
);
	import lzvn_pkg::*;

	logic [63:0] word_q;
	logic [3:0]  wcnt_q;
	logic        valid_q;
	logic [63:0] odata_q;
	logic [3:0]  ocnt_q;
	logic [2:0]  ost_q;
	logic [31:0] olen_q;
	logic        olast_q;

	assign busy      = valid_q && !m_tready;
	assign word_full = (wcnt_q == 4'(OUT_WORD_BYTES));
	assign m_tvalid  = valid_q;
	assign m_tlast   = olast_q;
	assign m_tdata   = {1'b0, olen_q, ost_q, ocnt_q, odata_q};

	// Collect bytes, flush a full word when another byte arrives, close the step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q  <= '0;
			wcnt_q  <= '0;
			valid_q <= 1'b0;
			olast_q <= 1'b0;
			odata_q <= '0;
			ocnt_q  <= '0;
			ost_q   <= '0;
			olen_q  <= '0;
		end else begin
			if (m_tready) valid_q <= 1'b0;
			if (ctl.put) begin
				if (word_full) begin
					valid_q <= 1'b1;
					odata_q <= word_q;
					ocnt_q  <= wcnt_q;
					ost_q   <= ST_RUN;
					olen_q  <= ctl.pos;
					olast_q <= 1'b0;
					word_q  <= {56'b0, ctl.data};
					wcnt_q  <= 4'd1;
				end else begin
					word_q[8*wcnt_q[2:0] +: 8] <= ctl.data;
					wcnt_q <= wcnt_q + 4'd1;
				end
			end else if (ctl.fin) begin
				if (wcnt_q != 4'd0 || ctl.status != ST_RUN) begin
					valid_q <= 1'b1;
					odata_q <= word_q;
					ocnt_q  <= wcnt_q;
					ost_q   <= ctl.status;
					olen_q  <= ctl.fpos;
					olast_q <= 1'b1;
				end
				word_q <= '0;
				wcnt_q <= '0;
			end
		end
	end
endmodule
`default_nettype wire

[design/lzvn_stream_decoder_unit.sv]
// LZVN stream decoder top level: opcode parser, match-copy sequencer and history
// Takes one compressed byte per beat on s_* (tuser = first) and gives decoded bytes
// on m_* in words of up to eight. A header byte that does not finish an opcode, and
// any byte that arrives after a stop, goes straight back to idle; any other byte is
// decoded and then closes the result beat in a final step.
// A match adds a distance check, then a read step and a write step per copied byte,
// as every byte goes through the single read port of the 64 KiB history RAM and is
// written back before the next read. Stalls on m_tready can hold the write and closing steps.
// The history RAM has no reset; only bytes written in the current stream are read.
`default_nettype none
module lzvn_stream_decoder_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // in_byte
	input  wire logic         s_tuser,   // first
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [103:0]      m_tdata,   // out_data, byte_count, status, total_length, pad
	output logic              m_tlast,   // last
	input  wire logic         cfg_we,
	input  wire logic         cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import lzvn_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MCHK = 5'b00010,
		S_MRD  = 5'b00100,
		S_MWR  = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

	state_t      state_q;
	logic [31:0] src_len_q, out_cap_q;
	logic [31:0] out_pos_q, in_pos_q;
	logic [15:0] prev_d_q;
	logic [7:0]  h0_q, h1_q;
	logic [1:0]  hcnt_q;
	logic [8:0]  lit_q, mlen_q;
	logic        stopped_q;
	logic [2:0]  st_q;

	pack_ctl_t   ctl;
	logic        pk_busy, pk_full;
	logic [7:0]  rd_data;
	logic        ram_we, ram_re;
	logic [HIST_AW-1:0] ram_waddr;
	logic [7:0]  ram_wdata;

	logic        acc, clr;
	logic [31:0] e_out, e_in;
	logic [1:0]  e_hcnt;
	logic [8:0]  e_lit, e_mlen;
	logic        e_stop, start_chk, start_fail, hdr_done, overrun, has_dist;
	logic [7:0]  hb0, hb1;
	kind_t       kind;
	logic [8:0]  dec_lit, dec_mlen;
	logic [15:0] dec_dist;
	logic [31:0] in_pos_n, out_pos_n;
	logic        mw_go;

	assign s_tready = (state_q == S_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign clr      = s_tuser;

	// Stream state as seen by this beat, after an optional restart
	assign e_out  = clr ? '0 : out_pos_q;
	assign e_in   = clr ? '0 : in_pos_q;
	assign e_hcnt = clr ? '0 : hcnt_q;
	assign e_lit  = clr ? '0 : lit_q;
	assign e_mlen = clr ? '0 : mlen_q;
	assign e_stop = clr ? 1'b0 : stopped_q;
	assign start_chk  = (e_in == '0) && (e_hcnt == '0) && (e_lit == '0);
	assign start_fail = start_chk && (out_cap_q < 32'd8 || src_len_q < 32'd8);
	assign in_pos_n  = e_in + 32'd1;
	assign out_pos_n = e_out + 32'd1;

	// Opcode header decode
	assign hb0      = (e_hcnt == 2'd0) ? s_tdata : h0_q;
	assign hb1      = (e_hcnt == 2'd1) ? s_tdata : h1_q;
	assign kind     = kind_of(hb0);
	assign hdr_done = ({1'b0, e_hcnt} + 3'd1) >= {1'b0, hdr_len(kind)};

	always_comb begin
		dec_lit  = '0;
		dec_mlen = '0;
		dec_dist = '0;
		has_dist = 1'b0;
		unique case (kind)
			K_SMLD: begin
				dec_lit  = {7'b0, hb0[7:6]};
				dec_mlen = {6'b0, hb0[5:3]} + 9'd3;
				dec_dist = {5'b0, hb0[2:0], hb1};
				has_dist = 1'b1;
			end
			K_PRED: begin
				dec_lit  = {7'b0, hb0[7:6]};
				dec_mlen = {6'b0, hb0[5:3]} + 9'd3;
			end
			K_LRGD: begin
				dec_lit  = {7'b0, hb0[7:6]};
				dec_mlen = {6'b0, hb0[5:3]} + 9'd3;
				dec_dist = {s_tdata, hb1};
				has_dist = 1'b1;
			end
			K_MEDD: begin
				dec_lit  = {7'b0, hb0[4:3]};
				dec_mlen = {4'b0, hb0[2:0], hb1[1:0]} + 9'd3;
				dec_dist = {2'b0, s_tdata, hb1[7:2]};
				has_dist = 1'b1;
			end
			K_SMLL: dec_lit  = {5'b0, hb0[3:0]};
			K_LRGL: dec_lit  = {1'b0, hb1} + 9'd16;
			K_SMLM: dec_mlen = {5'b0, hb0[3:0]};
			K_LRGM: dec_mlen = {1'b0, hb1} + 9'd16;
			default: ;
		endcase
	end

	assign overrun = ({2'b0, in_pos_n} + {25'b0, dec_lit} + 34'd8) > {2'b0, src_len_q};
	assign mw_go   = !(pk_full && pk_busy);

	// History write and packer control: literals in idle, copied bytes in the write step, close in the final step
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = s_tdata;
		ram_waddr = e_out[HIST_AW-1:0];
		ram_re    = (state_q == S_MRD);
		ctl       = '0;
		ctl.status = st_q;
		ctl.fpos   = out_pos_q;
		if (acc && !e_stop && !start_fail && e_lit != '0) begin
			ram_we   = 1'b1;
			ctl.put  = 1'b1;
			ctl.data = s_tdata;
			ctl.pos  = e_out;
		end
		if (state_q == S_MWR && mw_go) begin
			ram_we    = 1'b1;
			ram_wdata = rd_data;
			ram_waddr = out_pos_q[HIST_AW-1:0];
			ctl.put   = 1'b1;
			ctl.data  = rd_data;
			ctl.pos   = out_pos_q;
		end
		if (state_q == S_FIN && !pk_busy) ctl.fin = 1'b1;
	end

	lzvn_ram #(.WIDTH(8), .DEPTH(HISTORY_BYTES)) u_hist (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (HIST_AW'(out_pos_q - {16'b0, prev_d_q})),
		.rdata (rd_data)
	);

	lzvn_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.busy      (pk_busy),
		.word_full (pk_full),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_len_q <= '0;
			out_cap_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_LEN: src_len_q <= cfg_data;
				REG_OUT_CAP: out_cap_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Parser and match-copy sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_pos_q <= '0;
			in_pos_q  <= '0;
			prev_d_q  <= '0;
			h0_q      <= '0;
			h1_q      <= '0;
			hcnt_q    <= '0;
			lit_q     <= '0;
			mlen_q    <= '0;
			stopped_q <= 1'b0;
			st_q      <= ST_RUN;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc) begin
					out_pos_q <= e_out;
					in_pos_q  <= e_in;
					hcnt_q    <= e_hcnt;
					lit_q     <= e_lit;
					mlen_q    <= e_mlen;
					stopped_q <= e_stop;
					st_q      <= ST_RUN;
					if (clr) prev_d_q <= '0;
					if (e_stop) begin
						state_q <= S_IDLE;
					end else if (start_fail) begin
						stopped_q <= 1'b1;
						st_q      <= (out_cap_q < 32'd8) ? ST_FULL : ST_OVERRUN;
						state_q   <= S_FIN;
					end else if (e_lit != '0) begin
						// Literal byte: emit it, then copy the match after the last one
						in_pos_q  <= in_pos_n;
						lit_q     <= e_lit - 9'd1;
						out_pos_q <= out_pos_n;
						if (out_pos_n == out_cap_q) begin
							stopped_q <= 1'b1;
							lit_q     <= '0;
							mlen_q    <= '0;
							st_q      <= ST_FULL;
							state_q   <= S_FIN;
						end else if (e_lit == 9'd1 && e_mlen != '0) begin
							state_q <= S_MCHK;
						end else begin
							state_q <= S_FIN;
						end
					end else begin
						in_pos_q <= in_pos_n;
						if (e_hcnt == 2'd0) h0_q <= s_tdata;
						if (e_hcnt == 2'd1) h1_q <= s_tdata;
						if (!hdr_done) begin
							hcnt_q  <= e_hcnt + 2'd1;
							state_q <= S_IDLE;
						end else begin
							hcnt_q  <= '0;
							state_q <= S_FIN;
							if (kind == K_EOS || kind == K_UDEF || overrun) begin
								stopped_q <= 1'b1;
								lit_q     <= '0;
								mlen_q    <= '0;
								st_q      <= (kind == K_EOS) ? ST_END :
								             (kind == K_UDEF) ? ST_BAD_OP : ST_OVERRUN;
							end else begin
								if (has_dist) prev_d_q <= dec_dist;
								lit_q  <= dec_lit;
								mlen_q <= dec_mlen;
								if (dec_lit == '0 && dec_mlen != '0) state_q <= S_MCHK;
							end
						end
					end
				end
				S_MCHK: begin
					// Reject distance zero or one beyond the decoded bytes
					if (prev_d_q == '0 || {16'b0, prev_d_q} > out_pos_q) begin
						stopped_q <= 1'b1;
						lit_q     <= '0;
						mlen_q    <= '0;
						st_q      <= ST_BAD_DST;
						state_q   <= S_FIN;
					end else begin
						state_q <= S_MRD;
					end
				end
				S_MRD: state_q <= S_MWR;
				S_MWR: if (mw_go) begin
					out_pos_q <= out_pos_q + 32'd1;
					mlen_q    <= mlen_q - 9'd1;
					if (out_pos_q + 32'd1 == out_cap_q) begin
						stopped_q <= 1'b1;
						lit_q     <= '0;
						mlen_q    <= '0;
						st_q      <= ST_FULL;
						state_q   <= S_FIN;
					end else if (mlen_q == 9'd1) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_MRD;
					end
				end
				S_FIN: if (!pk_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/lzvn_chk.sv]
// Port checker for the LZVN stream decoder, bound to the top level
`default_nettype none
`include "lzvn_stream_decoder_unit_assert.svh"
module lzvn_chk (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [103:0] m_tdata,
	input wire logic         m_tlast
);
	`LZVN_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")
	`LZVN_ASSERT(a_count, m_tvalid |-> m_tdata[67:64] <= 4'd8, "byte count above eight")
	`LZVN_ASSERT(a_stlast, m_tvalid && m_tdata[70:68] != 3'd0 |-> m_tlast, "status on a beat that is not last")
	`LZVN_ASSERT(a_empty, m_tvalid && m_tdata[67:64] == 4'd0 |-> m_tdata[70:68] != 3'd0 && m_tdata[70:68] <= 3'd5, "empty beat without a valid stop status")
	`LZVN_ASSERT_ANY(a_rst, !arst_n |-> !m_tvalid, "result beat during reset")
endmodule

bind lzvn_stream_decoder_unit lzvn_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the LZVN stream decoder: scoreboard, stimulus and top
`timescale 1ns/1ps
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lzvn_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int SETTLE_CYCLES = 24;

	typedef struct {
		bit [63:0] data;
		bit [3:0]  cnt;
		bit [2:0]  st;
		bit [31:0] total;
		bit        last;
	} out_word_t;

	typedef struct {
		bit [7:0] b;
		bit       f;
	} in_beat_t;

	// Predicts decoded words from accepted bytes and checks result beats in order
	class decode_scoreboard;
		bit [31:0] src_len, out_cap;
		bit [7:0]  hist [65536];
		bit [31:0] out_pos, in_pos;
		bit [15:0] prev_dist;
		bit [23:0] hdr;
		int        hdr_cnt, lits_left, match_left;
		bit        halted;
		bit [7:0]  step_bytes [$];
		out_word_t expected_words [$];

		static function kind_t opcode_kind(bit [7:0] b);
			if (b >= 8'hF0) return (b == 8'hF0) ? K_LRGM : K_SMLM;
			if (b >= 8'hE0) return (b == 8'hE0) ? K_LRGL : K_SMLL;
			if (b >= 8'hA0 && b <= 8'hBF) return K_MEDD;
			if ((b >= 8'h70 && b <= 8'h7F) || (b >= 8'hD0 && b <= 8'hDF)) return K_UDEF;
			if (b[2:0] == 3'd7) return K_LRGD;
			if (b[2:0] == 3'd6) begin
				if (b == 8'h06) return K_EOS;
				if (b == 8'h0E || b == 8'h16) return K_NOP;
				if (b < 8'h40) return K_UDEF;
				return K_PRED;
			end
			return K_SMLD;
		endfunction

		static function int header_size(kind_t k);
			case (k)
				K_LRGD, K_MEDD:         return 3;
				K_SMLD, K_LRGL, K_LRGM: return 2;
				default:                return 1;
			endcase
		endfunction

		function void clear_stream();
			out_pos = 0;
			in_pos = 0;
			prev_dist = 0;
			hdr = 0;
			hdr_cnt = 0;
			lits_left = 0;
			match_left = 0;
			halted = 0;
		endfunction

		function new();
			src_len = 0;
			out_cap = 0;
			clear_stream();
		endfunction

		function void put(bit [7:0] b);
			hist[out_pos[15:0]] = b;
			step_bytes.push_back(b);
			out_pos++;
		endfunction

		function bit [2:0] copy_match();
			bit [31:0] src_pos;
			if (prev_dist == 0 || prev_dist > out_pos) begin
				match_left = 0;
				return ST_BAD_DST;
			end
			while (match_left > 0) begin
				src_pos = out_pos - prev_dist;
				put(hist[src_pos[15:0]]);
				match_left--;
				if (out_pos == out_cap) begin
					match_left = 0;
					return ST_FULL;
				end
			end
			return ST_RUN;
		endfunction

		function void pack_words(bit [2:0] st);
			out_word_t w;
			int n, pos, chunk;
			bit [31:0] base;
			n = step_bytes.size();
			if (n == 0) begin
				if (st != ST_RUN) begin
					w = '{64'd0, 4'd0, st, out_pos, 1'b1};
					expected_words.push_back(w);
				end
				return;
			end
			base = out_pos - 32'(n);
			pos = 0;
			while (pos < n) begin
				chunk = (n - pos > 8) ? 8 : n - pos;
				w.data = 0;
				for (int i = 0; i < chunk; i++) w.data[8*i +: 8] = step_bytes[pos + i];
				pos += chunk;
				w.cnt = 4'(chunk);
				w.st = (pos == n) ? st : ST_RUN;
				w.total = base + 32'(pos);
				w.last = (pos == n);
				expected_words.push_back(w);
			end
		endfunction

		function void halt(bit [2:0] st);
			halted = 1;
			hdr = 0;
			hdr_cnt = 0;
			lits_left = 0;
			match_left = 0;
			pack_words(st);
		endfunction

		// Note one accepted input beat and queue the words it causes
		function void take_byte(bit [7:0] b, bit f);
			bit [7:0] h0, h1, h2;
			int lit, mlen;
			bit [15:0] op_dist;
			bit has_dist;
			bit [2:0] st;
			kind_t k;
			bit [15:0] mid;
			step_bytes.delete();
			lit = 0;
			mlen = 0;
			op_dist = 0;
			has_dist = 0;
			if (f) clear_stream();
			if (halted) return;
			if (in_pos == 0 && hdr_cnt == 0 && lits_left == 0) begin
				if (out_cap < 8) begin
					halt(ST_FULL);
					return;
				end
				if (src_len < 8) begin
					halt(ST_OVERRUN);
					return;
				end
			end
			// literal of the current opcode
			if (lits_left > 0) begin
				in_pos++;
				lits_left--;
				put(b);
				if (out_pos == out_cap) begin
					halt(ST_FULL);
					return;
				end
				if (lits_left == 0 && match_left > 0) begin
					st = copy_match();
					if (st != ST_RUN) begin
						halt(st);
						return;
					end
				end
				pack_words(ST_RUN);
				return;
			end
			// collect header bytes
			hdr[8*hdr_cnt +: 8] = b;
			hdr_cnt++;
			in_pos++;
			h0 = hdr[7:0];
			k = opcode_kind(h0);
			if (hdr_cnt < header_size(k)) return;
			h1 = hdr[15:8];
			h2 = hdr[23:16];
			hdr = 0;
			hdr_cnt = 0;
			case (k)
				K_EOS: begin
					halt(ST_END);
					return;
				end
				K_UDEF: begin
					halt(ST_BAD_OP);
					return;
				end
				K_SMLD: begin
					lit = h0[7:6];
					mlen = h0[5:3] + 3;
					op_dist = {5'd0, h0[2:0], h1};
					has_dist = 1;
				end
				K_PRED: begin
					lit = h0[7:6];
					mlen = h0[5:3] + 3;
				end
				K_LRGD: begin
					lit = h0[7:6];
					mlen = h0[5:3] + 3;
					op_dist = {h2, h1};
					has_dist = 1;
				end
				K_MEDD: begin
					lit = h0[4:3];
					mlen = {h0[2:0], h1[1:0]} + 3;
					mid = {h2, h1};
					op_dist = {2'd0, mid[15:2]};
					has_dist = 1;
				end
				K_SMLL: lit = h0[3:0];
				K_LRGL: lit = h1 + 16;
				K_SMLM: mlen = h0[3:0];
				K_LRGM: mlen = h1 + 16;
				default: ;
			endcase
			if ({32'd0, in_pos} + lit + 8 > {32'd0, src_len}) begin
				halt(ST_OVERRUN);
				return;
			end
			if (has_dist) prev_dist = op_dist;
			lits_left = lit;
			match_left = mlen;
			if (lit == 0 && mlen > 0) begin
				st = copy_match();
				if (st != ST_RUN) begin
					halt(st);
					return;
				end
			end
			pack_words(ST_RUN);
		endfunction

		// Compare one result beat with the oldest expected word; empty string when equal
		function string match_word(bit [103:0] td, bit tl);
			out_word_t w;
			string msg;
			msg = "";
			if (expected_words.size() == 0) return "result beat with no word expected";
			w = expected_words.pop_front();
			if (td[63:0] !== w.data)
				msg = {msg, $sformatf(" out_data %h/%h", td[63:0], w.data)};
			if (td[67:64] !== w.cnt)
				msg = {msg, $sformatf(" byte_count %0d/%0d", td[67:64], w.cnt)};
			if (td[70:68] !== w.st)
				msg = {msg, $sformatf(" status %0d/%0d", td[70:68], w.st)};
			if (td[102:71] !== w.total)
				msg = {msg, $sformatf(" total_length %0d/%0d", td[102:71], w.total)};
			if (tl !== w.last)
				msg = {msg, $sformatf(" last %0d/%0d", tl, w.last)};
			return msg;
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;
	logic         m_tlast;
	logic         cfg_we;
	logic         cfg_index;
	logic [31:0]  cfg_data;

	decode_scoreboard board;
	in_beat_t stim_q [$];
	int  errors;
	int  cycles;
	bit  s_fire;
	bit  calm;
	int  stall_left;

	lzvn_stream_decoder_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("mismatch at cycle %0d:%s", cycles, msg);
		errors++;
	endtask

	// Sample both handshakes at the rising edge
	always @(posedge clk) begin
		string msg;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("lzvn_stream_decoder_unit regression: fail");
			$finish;
		end
		s_fire = arst_n && s_tvalid && s_tready;
		if (s_fire) board.take_byte(s_tdata, s_tuser);
		if (arst_n && m_tvalid && m_tready) begin
			msg = board.match_word(m_tdata, m_tlast);
			if (msg != "") report(msg);
		end
	end

	// Receiver: stall in short bursts unless the run is in its calm stretch
	always @(negedge clk) begin
		if (stall_left > 0) begin
			m_tready = 0;
			stall_left--;
		end else begin
			m_tready = 1;
			if (!calm && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 3);
		end
	end

	task automatic add_byte(input bit [7:0] b, input bit f = 0);
		in_beat_t t;
		t.b = b;
		t.f = f;
		stim_q.push_back(t);
	endtask

	task automatic add_randoms(input int n);
		for (int i = 0; i < n; i++) add_byte(8'($urandom_range(0, 255)));
	endtask

	// Send every queued beat, with sender gaps outside the calm stretch
	task automatic send_all();
		in_beat_t t;
		while (stim_q.size() > 0) begin
			t = stim_q.pop_front();
			if (!calm && $urandom_range(0, 5) == 0) begin
				s_tvalid = 0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
			s_tvalid = 1;
			s_tdata = t.b;
			s_tuser = t.f;
			do @(negedge clk); while (!s_fire);
		end
		s_tvalid = 0;
	endtask

	// Hold until every expected word has come and the block has gone quiet
	task automatic settle();
		while (board.expected_words.size() > 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input bit [31:0] val);
		settle();
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		if (idx == REG_SRC_LEN) board.src_len = val;
		else board.out_cap = val;
	endtask

	// Build one stream; tidy streams are well formed, others carry noise
	task automatic build_stream(input bit tidy, output int nbytes);
		int start, produced, ops, sel, d, n, lit, m;
		bit [15:0] pd;
		bit [7:0] h0;
		bit [15:0] h12;
		bit found;
		start = stim_q.size();
		produced = 0;
		pd = 0;
		ops = $urandom_range(3, 8);
		n = $urandom_range(1, 15);
		add_byte(8'(8'hE0 | n), 1);
		add_randoms(n);
		produced = n;
		for (int op = 0; op < ops; op++) begin
			sel = $urandom_range(0, 9);
			found = 0;
			case (sel)
				0, 1: begin
					n = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 15);
					if (n >= 16) begin
						add_byte(8'hE0);
						add_byte(8'(n - 16));
					end else add_byte(8'(8'hE0 | n));
					add_randoms(n);
					produced += n;
				end
				2, 3: begin
					d = $urandom_range(1, (produced < 1535) ? produced : 1535);
					for (int t = 0; t < 40 && !found; t++) begin
						h0 = {5'($urandom_range(0, 31)), 3'(d >> 8)};
						found = (decode_scoreboard::opcode_kind(h0) == K_SMLD);
					end
					if (found) begin
						add_byte(h0);
						add_byte(d[7:0]);
						lit = h0[7:6];
						add_randoms(lit);
						produced += lit + h0[5:3] + 3;
						pd = d;
					end
				end
				4: begin
					d = $urandom_range(1, (produced < 16383) ? produced : 16383);
					h0 = 8'hA0 | 8'($urandom_range(0, 31));
					m = $urandom_range(0, 3);
					h12 = {d[13:0], 2'(m)};
					add_byte(h0);
					add_byte(h12[7:0]);
					add_byte(h12[15:8]);
					lit = h0[4:3];
					add_randoms(lit);
					produced += lit + {h0[2:0], 2'(m)} + 3;
					pd = d;
				end
				5: begin
					d = $urandom_range(1, (produced < 65535) ? produced : 65535);
					for (int t = 0; t < 40 && !found; t++) begin
						h0 = {5'($urandom_range(0, 31)), 3'b111};
						found = (decode_scoreboard::opcode_kind(h0) == K_LRGD);
					end
					if (found) begin
						add_byte(h0);
						add_byte(d[7:0]);
						add_byte(d[15:8]);
						lit = h0[7:6];
						add_randoms(lit);
						produced += lit + h0[5:3] + 3;
						pd = d;
					end
				end
				6: if (pd != 0) begin
					for (int t = 0; t < 40 && !found; t++) begin
						h0 = {5'($urandom_range(0, 31)), 3'b110};
						found = (decode_scoreboard::opcode_kind(h0) == K_PRED);
					end
					if (found) begin
						add_byte(h0);
						lit = h0[7:6];
						add_randoms(lit);
						produced += lit + h0[5:3] + 3;
					end
				end
				7: if (pd != 0) begin
					if ($urandom_range(0, 3) == 0) begin
						n = $urandom_range(0, 20);
						add_byte(8'hF0);
						add_byte(8'(n));
						produced += n + 16;
					end else begin
						n = $urandom_range(1, 15);
						add_byte(8'(8'hF0 | n));
						produced += n;
					end
				end
				8: add_byte($urandom_range(0, 1) ? 8'h0E : 8'h16);
				default: begin
					if (tidy) begin
						add_byte(8'hE1);
						add_randoms(1);
						produced++;
					end else add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
				end
			endcase
		end
		if (tidy || $urandom_range(0, 1)) add_byte(8'h06);
		nbytes = stim_q.size() - start;
	endtask

	initial begin
		int sent, len_a, len_b, longest, mode;
		bit tidy;
		board = new();
		errors = 0;
		cycles = 0;
		calm = 0;
		stall_left = 0;
		s_fire = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		m_tready = 0;
		cfg_we = 0;
		cfg_index = REG_SRC_LEN;
		cfg_data = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// capacity below eight, then a byte ignored after the stop
		write_reg(REG_SRC_LEN, 32'd0);
		write_reg(REG_OUT_CAP, 32'd0);
		add_byte(8'h06, 1);
		add_byte(8'hFF);
		send_all();

		// source shorter than eight bytes
		write_reg(REG_OUT_CAP, 32'hFFFF_FFFF);
		write_reg(REG_SRC_LEN, 32'd7);
		add_byte(8'h00, 1);
		send_all();

		// every opcode kind but the large literal, then undefined opcode and both bad distances
		write_reg(REG_SRC_LEN, 32'hFFFF_FFFF);
		add_byte(8'hE3, 1);
		add_byte(8'h00); add_byte(8'hFF); add_byte(8'h5A);
		add_byte(8'h00); add_byte(8'h01);
		add_byte(8'hA0); add_byte(8'h04); add_byte(8'h00);
		add_byte(8'h07); add_byte(8'h02); add_byte(8'h00);
		add_byte(8'h46); add_byte(8'h80);
		add_byte(8'hF2);
		add_byte(8'hF0); add_byte(8'h00);
		add_byte(8'h0E); add_byte(8'h16);
		add_byte(8'h06);
		add_byte(8'h70, 1);
		add_byte(8'h00, 1); add_byte(8'h00);
		add_byte(8'hE1, 1); add_byte(8'hAA); add_byte(8'h01); add_byte(8'h05);
		send_all();

		// output stops at exactly the capacity
		write_reg(REG_OUT_CAP, 32'd8);
		add_byte(8'hE2, 1); add_byte(8'h11); add_byte(8'h22);
		add_byte(8'h38); add_byte(8'h01);
		send_all();

		// literals running past the source end
		write_reg(REG_OUT_CAP, 32'hFFFF_FFFF);
		write_reg(REG_SRC_LEN, 32'd12);
		add_byte(8'hE5, 1);
		add_randoms(5);
		send_all();

		// random phases of two streams each under one setting
		sent = 0;
		while (sent < 330) begin
			calm = (sent > 270);
			tidy = ($urandom_range(0, 4) != 0);
			build_stream(tidy, len_a);
			build_stream($urandom_range(0, 4) != 0, len_b);
			longest = (len_a > len_b) ? len_a : len_b;
			mode = $urandom_range(0, 9);
			case (mode)
				0, 1: begin
					write_reg(REG_OUT_CAP, $urandom_range(8, 60));
					write_reg(REG_SRC_LEN, 32'hFFFF_FFFF);
				end
				2: begin
					write_reg(REG_OUT_CAP, $urandom_range(0, 7));
					write_reg(REG_SRC_LEN, $urandom);
				end
				3: begin
					write_reg(REG_OUT_CAP, 32'hFFFF_FFFF);
					write_reg(REG_SRC_LEN, $urandom_range(0, 7));
				end
				4, 5: begin
					write_reg(REG_OUT_CAP, $urandom | 32'h0001_0000);
					write_reg(REG_SRC_LEN, longest + 8 - $urandom_range(0, 10));
				end
				default: begin
					write_reg(REG_OUT_CAP, $urandom | 32'h0001_0000);
					write_reg(REG_SRC_LEN, ($urandom | 32'h0001_0000) + longest + 8);
				end
			endcase
			sent += stim_q.size();
			send_all();
		end

		settle();
		if (errors == 0 && board.expected_words.size() == 0) begin
			$display("lzvn_stream_decoder_unit regression: pass");
		end else begin
			$display("lzvn_stream_decoder_unit regression: fail");
		end
		$finish;
	end
endmodule
`default_nettype wire
